// ===== rtl/core/vlpd_pkg.sv =====
// Shared types and constants for the varint length-prefix deframer.
`timescale 1ns / 1ps
`default_nettype none
package vlpd_pkg;

    localparam int MAX_HEADER_BYTES_DEF = 5;
    localparam int INDEX_WIDTH_DEF      = 16;

    localparam int LEN_W    = 35;
    localparam int BYTE_W   = 8;
    localparam int IDX_OUT_W = 16;
    localparam int TDATA_W  = 64;

    localparam logic [6:0] VARINT_DATA_MASK = 7'h7f;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_DROP    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_EMPTY   = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE          = 2'd0,
        ERR_VARINT_CUT    = 2'd1,
        ERR_VARINT_LONG   = 2'd2,
        ERR_PAYLOAD_SHORT = 2'd3
    } t_err;

    typedef struct packed {
        t_kind               kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [IDX_OUT_W-1:0] pkt_index;
        logic                pkt_start;
        logic                pkt_end;
        logic [LEN_W-1:0]    pkt_length;
        t_err                error_code;
        logic                batch_end;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/core/vlpd_decode.sv =====
// Header/payload decode state and per-byte result generation.
`timescale 1ns / 1ps
`default_nettype none
module vlpd_decode #(
    parameter int MAX_HEADER_BYTES = vlpd_pkg::MAX_HEADER_BYTES_DEF,
    parameter int INDEX_WIDTH      = vlpd_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_accept,
    input  wire logic [7:0]               i_byte,
    input  wire logic                     i_last,
    output logic                          o_res_valid,
    output vlpd_pkg::t_result             o_res
);
    import vlpd_pkg::*;

    localparam int HCW = $clog2(MAX_HEADER_BYTES + 1);
    localparam int SHW = HCW + 3;
    localparam int XW  = 7 * MAX_HEADER_BYTES + LEN_W;

    t_phase                 r_phase,        n_phase;
    logic [LEN_W-1:0]       r_length,       n_length;
    logic [HCW-1:0]         r_header_count, n_header_count;
    logic [LEN_W-1:0]       r_bytes_left,   n_bytes_left;
    logic [INDEX_WIDTH-1:0] r_pkt_cnt,      n_pkt_cnt;

    logic [SHW-1:0]              shift_amt;
    logic [XW-1:0]               shifted;
    logic [LEN_W-1:0]            accum_new;
    logic [INDEX_WIDTH+15:0]     idx_ext;
    logic [INDEX_WIDTH-1:0]      pkt_cnt_inc;
    logic [LEN_W-1:0]            left_dec;

    // 7 * header_count as shift-and-subtract
    assign shift_amt   = {r_header_count, 3'b000} - {3'b000, r_header_count};
    assign shifted     = XW'(i_byte[6:0] & VARINT_DATA_MASK) << shift_amt;
    assign accum_new   = r_length | shifted[LEN_W-1:0];
    assign idx_ext     = {16'b0, r_pkt_cnt};
    assign pkt_cnt_inc = (r_pkt_cnt != '1) ? r_pkt_cnt + 1'b1 : r_pkt_cnt;
    assign left_dec    = (r_bytes_left != '0) ? r_bytes_left - 1'b1 : r_bytes_left;

    always_comb begin
        n_phase        = r_phase;
        n_length       = r_length;
        n_header_count = r_header_count;
        n_bytes_left   = r_bytes_left;
        n_pkt_cnt      = r_pkt_cnt;
        o_res_valid    = 1'b0;
        o_res.kind         = KIND_PAYLOAD;
        o_res.payload_byte = '0;
        o_res.pkt_index    = idx_ext[15:0];
        o_res.pkt_start    = 1'b0;
        o_res.pkt_end      = 1'b0;
        o_res.pkt_length   = '0;
        o_res.error_code   = ERR_NONE;
        o_res.batch_end    = i_last;

        case (r_phase)
            PH_HEADER: begin
                if (32'(r_header_count) >= MAX_HEADER_BYTES) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_VARINT_LONG;
                    n_phase          = PH_DROP;
                end else begin
                    n_length       = accum_new;
                    n_header_count = r_header_count + 1'b1;
                    if (i_byte[7]) begin
                        if (i_last) begin
                            o_res_valid      = 1'b1;
                            o_res.kind       = KIND_ERROR;
                            o_res.error_code = ERR_VARINT_CUT;
                            n_phase          = PH_DROP;
                        end
                    end else if (accum_new == '0) begin
                        o_res_valid    = 1'b1;
                        o_res.kind     = KIND_EMPTY;
                        o_res.pkt_end  = 1'b1;
                        n_pkt_cnt      = pkt_cnt_inc;
                        n_phase        = PH_HEADER;
                        n_length       = '0;
                        n_header_count = '0;
                        n_bytes_left   = '0;
                    end else if (i_last) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_PAYLOAD_SHORT;
                        o_res.pkt_length = accum_new;
                        n_phase          = PH_DROP;
                    end else begin
                        n_bytes_left = accum_new;
                        n_phase      = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_res_valid = 1'b1;
                if (r_bytes_left > LEN_W'(1) && i_last) begin
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_PAYLOAD_SHORT;
                    o_res.pkt_length = r_length;
                    n_phase          = PH_DROP;
                end else begin
                    o_res.payload_byte = i_byte;
                    o_res.pkt_start    = (r_bytes_left == r_length);
                    o_res.pkt_end      = (r_bytes_left <= LEN_W'(1));
                    o_res.pkt_length   = r_length;
                    n_bytes_left       = left_dec;
                    if (left_dec == '0) begin
                        n_pkt_cnt      = pkt_cnt_inc;
                        n_phase        = PH_HEADER;
                        n_length       = '0;
                        n_header_count = '0;
                    end
                end
            end
            default: begin
                // drop until the batch ends
            end
        endcase

        // batch end returns everything to its starting state
        if (i_last) begin
            n_phase        = PH_HEADER;
            n_length       = '0;
            n_header_count = '0;
            n_bytes_left   = '0;
            n_pkt_cnt      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HEADER;
            r_length       <= '0;
            r_header_count <= '0;
            r_bytes_left   <= '0;
            r_pkt_cnt      <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_length       <= n_length;
            r_header_count <= n_header_count;
            r_bytes_left   <= n_bytes_left;
            r_pkt_cnt      <= n_pkt_cnt;
        end
    end

    a_batch_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> r_phase == PH_HEADER && r_header_count == '0
                               && r_pkt_cnt == '0 && r_length == '0)
        else $error("state not cleared after batch end");

    a_payload_due: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_bytes_left != '0 && r_bytes_left <= r_length)
        else $error("payload phase with no bytes due");

    a_header_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_header_count) <= MAX_HEADER_BYTES)
        else $error("header count beyond limit");

    a_error_coded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.kind == KIND_ERROR |-> o_res.error_code != ERR_NONE)
        else $error("error result without a code");

endmodule
`default_nettype wire

// ===== rtl/core/vlpd_out_reg.sv =====
// Output result register with valid/ready hand-off.
`timescale 1ns / 1ps
`default_nettype none
module vlpd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire vlpd_pkg::t_result i_res,
    output logic                   o_space,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output vlpd_pkg::t_result      o_res
);
    import vlpd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_res;

    // free when empty or being drained this cycle
    assign o_space = !r_valid || i_ready;
    assign n_valid = i_load || (r_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_space)
        else $error("result loaded over an undelivered one");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_ready && !i_load |=> !r_valid)
        else $error("delivered result still shown");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not shown");

endmodule
`default_nettype wire

// ===== rtl/core/varint_length_prefix_deframer_top.sv =====
// Top level of the LEB128 length-prefix deframer.
//
// Usage:
//   Slave stream: one raw byte per transaction in i_s_tdata[7:0], with
//   i_s_tlast marking the final byte of a batch. Each packet in the batch is
//   an unsigned LEB128 length (up to MAX_HEADER_BYTES bytes) and that many
//   payload bytes.
//   Master stream: at most one result per input byte. o_m_tuser holds the
//   result kind (payload byte, empty packet, error); o_m_tlast marks a result
//   caused by the batch's last byte. Header bytes that only carry length give
//   no result. After an error every remaining byte of the batch is dropped;
//   the consumer discards that batch.
//   Throughput: one byte per cycle, sustained while the receiver takes results,
//   set by the single decode pass between the state registers and the output register.
//   Output: a result is registered and appears on the master side in the
//   cycle after its byte's transaction.
//   Stall: o_s_tready follows the output register; it drops only while a
//   result is held and i_m_tready is low, so a stalled receiver pauses input
//   without losing or repeating anything.
//   Reset: synchronous, active low; clears the decode state and the output
//   valid. The end of every batch also returns the decoder to that state.
`timescale 1ns / 1ps
`default_nettype none
module varint_length_prefix_deframer_top #(
    parameter int MAX_HEADER_BYTES = vlpd_pkg::MAX_HEADER_BYTES_DEF,
    parameter int INDEX_WIDTH      = vlpd_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] in_byte
    input  wire logic        i_s_tlast,   // batch_last
    // master stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [vlpd_pkg::TDATA_W-1:0] o_m_tdata, // [7:0] payload_byte, [23:8] pkt_index,
                                          // [24] pkt_start, [25] pkt_end,
                                          // [60:26] pkt_length, [62:61] error_code,
                                          // [63] zero
    output logic [1:0]       o_m_tuser,   // [1:0] result_kind
    output logic             o_m_tlast    // batch_end
);
    import vlpd_pkg::*;

    logic    accept;
    logic    space;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign o_s_tready = space;
    assign accept     = i_s_tvalid && space;

    vlpd_decode #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES),
        .INDEX_WIDTH      (INDEX_WIDTH)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // hold the result until the receiver takes it
    vlpd_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept && res_valid),
        .i_res   (res),
        .o_space (space),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = {1'b0, out_res.error_code, out_res.pkt_length, out_res.pkt_end,
                        out_res.pkt_start, out_res.pkt_index, out_res.payload_byte};
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.batch_end;

    a_tready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while output stalled");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != KIND_PAYLOAD |-> o_m_tdata[7:0] == 8'd0)
        else $error("data byte on non-payload result");

    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && res_valid |=> o_m_tvalid)
        else $error("result not presented one cycle after its byte");

endmodule
`default_nettype wire

// ===== sim/vlpd_result_checker.sv =====
// Checker for the varint deframer: predicts results from input bytes and compares output.
`timescale 1ns / 1ps
module vlpd_result_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [7:0]  i_s_tdata,
    input  wire logic        i_s_tlast,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [63:0] i_m_tdata,
    input  wire logic [1:0]  i_m_tuser,
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_results,
    output int               o_error_results,
    output int               o_live_bytes,
    output int               o_stall_cycles
);
    import vlpd_pkg::*;

    localparam int MAX_PRINTED = 100;

    // decoder state as predicted
    t_phase             dec_phase = PH_HEADER;
    logic [LEN_W-1:0]   len_accum = '0;
    int                 hdr_taken = 0;
    logic [LEN_W-1:0]   left_to_go = '0;
    logic [IDX_OUT_W-1:0] pkt_count = '0;

    t_result due_results[$];

    int fail_cnt   = 0;
    int result_cnt = 0;
    int error_cnt  = 0;
    int live_cnt   = 0;
    int stall_cnt  = 0;

    task automatic restart_batch();
        dec_phase  = PH_HEADER;
        len_accum  = '0;
        hdr_taken  = 0;
        left_to_go = '0;
        pkt_count  = '0;
    endtask

    task automatic advance_packet();
        if (pkt_count != '1)
            pkt_count = pkt_count + 1'b1;
        dec_phase  = PH_HEADER;
        len_accum  = '0;
        hdr_taken  = 0;
        left_to_go = '0;
    endtask

    // Work out the result, if any, that one accepted byte causes.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        t_result r;
        bit      have;
        r           = '0;
        have        = 1'b0;
        r.pkt_index = pkt_count;
        r.batch_end = last;
        case (dec_phase)
            PH_HEADER: begin
                if (hdr_taken >= MAX_HEADER_BYTES_DEF) begin
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_VARINT_LONG;
                    have         = 1'b1;
                    dec_phase    = PH_DROP;
                end else begin
                    len_accum = len_accum | ({28'd0, b[6:0]} << (7 * hdr_taken));
                    hdr_taken++;
                    if (b[7]) begin
                        if (last) begin
                            r.kind       = KIND_ERROR;
                            r.error_code = ERR_VARINT_CUT;
                            have         = 1'b1;
                            dec_phase    = PH_DROP;
                        end
                    end else if (len_accum == '0) begin
                        r.kind    = KIND_EMPTY;
                        r.pkt_end = 1'b1;
                        have      = 1'b1;
                        advance_packet();
                    end else if (last) begin
                        r.kind       = KIND_ERROR;
                        r.error_code = ERR_PAYLOAD_SHORT;
                        r.pkt_length = len_accum;
                        have         = 1'b1;
                        dec_phase    = PH_DROP;
                    end else begin
                        left_to_go = len_accum;
                        dec_phase  = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (left_to_go > 1 && last) begin
                    r.kind       = KIND_ERROR;
                    r.error_code = ERR_PAYLOAD_SHORT;
                    r.pkt_length = len_accum;
                    have         = 1'b1;
                    dec_phase    = PH_DROP;
                end else begin
                    r.kind         = KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.pkt_start    = (left_to_go == len_accum);
                    r.pkt_end      = (left_to_go <= 1);
                    r.pkt_length   = len_accum;
                    have           = 1'b1;
                    if (left_to_go != '0)
                        left_to_go = left_to_go - 1'b1;
                    if (left_to_go == '0)
                        advance_packet();
                end
            end
            default: ;
        endcase
        if (have)
            due_results.push_back(r);
        if (last)
            restart_batch();
    endtask

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (fail_cnt < MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0h, expected %0h (result %0d)",
                     $time, what, got, want, result_cnt);
        fail_cnt++;
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.kind         = t_kind'(i_m_tuser);
        got.payload_byte = i_m_tdata[7:0];
        got.pkt_index    = i_m_tdata[23:8];
        got.pkt_start    = i_m_tdata[24];
        got.pkt_end      = i_m_tdata[25];
        got.pkt_length   = i_m_tdata[60:26];
        got.error_code   = t_err'(i_m_tdata[62:61]);
        got.batch_end    = i_m_tlast;
        if (due_results.size() == 0) begin
            flag_mismatch("result with nothing due", i_m_tdata, 64'd0);
            return;
        end
        want = due_results.pop_front();
        result_cnt++;
        if (want.kind == KIND_ERROR)
            error_cnt++;
        if (got.kind !== want.kind)
            flag_mismatch("result_kind", 64'(got.kind), 64'(want.kind));
        if (got.payload_byte !== want.payload_byte)
            flag_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
        if (got.pkt_index !== want.pkt_index)
            flag_mismatch("pkt_index", 64'(got.pkt_index), 64'(want.pkt_index));
        if (got.pkt_start !== want.pkt_start)
            flag_mismatch("pkt_start", 64'(got.pkt_start), 64'(want.pkt_start));
        if (got.pkt_end !== want.pkt_end)
            flag_mismatch("pkt_end", 64'(got.pkt_end), 64'(want.pkt_end));
        if (got.pkt_length !== want.pkt_length)
            flag_mismatch("pkt_length", 64'(got.pkt_length), 64'(want.pkt_length));
        if (got.error_code !== want.error_code)
            flag_mismatch("error_code", 64'(got.error_code), 64'(want.error_code));
        if (got.batch_end !== want.batch_end)
            flag_mismatch("batch_end", 64'(got.batch_end), 64'(want.batch_end));
        if (i_m_tdata[63] !== 1'b0)
            flag_mismatch("tdata pad bit", 64'(i_m_tdata[63]), 64'd0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restart_batch();
            due_results.delete();
        end else begin
            // drain first: a result never belongs to a byte taken at the same edge
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready) begin
                if (dec_phase != PH_DROP)
                    live_cnt++;
                decode_byte(i_s_tdata, i_s_tlast);
            end
            if (i_s_tvalid && !i_s_tready)
                stall_cnt++;
        end
        o_fail_count    <= fail_cnt;
        o_pending       <= due_results.size();
        o_results       <= result_cnt;
        o_error_results <= error_cnt;
        o_live_bytes    <= live_cnt;
        o_stall_cycles  <= stall_cnt;
    end

endmodule

// ===== sim/tb_varint_length_prefix_deframer_top.sv =====
// Testbench top for the varint deframer: clock, reset, byte stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_varint_length_prefix_deframer_top;

    // Live-byte goals per idling phase (bytes outside dropped runs).
    localparam int PHASE_BYTES = 600;
    localparam int HOLD_CYCLES = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] in_byte
    logic        s_tlast = 1'b0;   // batch_last

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [7:0] payload_byte, [23:8] pkt_index, [24] pkt_start,
                                   // [25] pkt_end, [60:26] pkt_length, [62:61] error_code
    logic [1:0]  m_tuser;          // [1:0] result_kind
    logic        m_tlast;          // batch_end

    int fail_count, pending, results, error_results, live_bytes, stall_cycles;

    int tx_idle_pct = 0;   // chance in 100 that the sender idles a cycle
    int rx_idle_pct = 0;   // chance in 100 that the receiver idles a cycle
    bit hold_req = 1'b0;
    bit rx_hold = 1'b0;
    int n_sent = 0;

    logic [7:0] batch_q[$];

    // Directed bytes: bit 8 marks the batch's last byte.
    logic [8:0] directed [25] = '{
        9'h100,                                    // lone empty packet
        9'h180,                                    // varint cut off by batch end
        9'h080, 9'h080, 9'h080, 9'h080, 9'h080,    // five header bytes with continuation,
        9'h001, 9'h033, 9'h1C4,                    // sixth is too many; rest is dropped
        9'h000, 9'h002, 9'h0FF, 9'h100,            // empty packet, then 2-byte payload
        9'h003, 9'h011, 9'h122,                    // payload cut short on a payload byte
        9'h105,                                    // batch ends on a header with length 5
        9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h07F,    // largest 35-bit length,
        9'h0A5, 9'h15A                             // then the batch stops early
    };

    always #1 clk = ~clk;

    varint_length_prefix_deframer_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser),
        .o_m_tlast  (m_tlast)
    );

    vlpd_result_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_s_tlast       (s_tlast),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .i_m_tlast       (m_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_results       (results),
        .o_error_results (error_results),
        .o_live_bytes    (live_bytes),
        .o_stall_cycles  (stall_cycles)
    );

    // Receiver: idle at random, or hold off entirely while a hold-off is running.
    always @(posedge clk) begin
        if (rx_hold)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Long receiver hold-off: the sender keeps offering, so the block fills
    // up and must stall its input.
    initial begin
        wait (hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Offer one byte and hold it until its transaction completes. Keep valid
    // high between back-to-back bytes; drop it only for an idle cycle.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        n_sent++;
    endtask

    task automatic send_batch();
        foreach (batch_q[i])
            send_byte(batch_q[i], i == batch_q.size() - 1);
    endtask

    // Append a LEB128 length of nbytes bytes (padded with zero groups when
    // nbytes exceeds the minimum).
    task automatic push_varint(input int unsigned len, input int nbytes);
        logic [7:0] v;
        for (int k = 0; k < nbytes; k++) begin
            v[6:0] = 7'(len >> (7 * k));
            v[7]   = (k < nbytes - 1);
            batch_q.push_back(v);
        end
    endtask

    // Mostly well-formed batches with random content; the rest is cut short,
    // carries an over-long header, or ends in noise.
    task automatic build_random_batch();
        int unsigned shape, npk, len, nb, sel, cut;
        batch_q.delete();
        shape = $urandom_range(99);
        npk   = $urandom_range(5, 1);
        for (int p = 0; p < npk; p++) begin
            sel = $urandom_range(99);
            if (sel < 15)
                len = 0;
            else if (sel < 80)
                len = $urandom_range(8, 1);
            else if (sel < 97)
                len = $urandom_range(40, 9);
            else
                len = $urandom_range(200, 128);
            nb = (len < 128) ? 1 : 2;
            if ($urandom_range(3) == 0)
                nb = $urandom_range(5, nb);
            push_varint(len, nb);
            repeat (len) batch_q.push_back(8'($urandom_range(255)));
        end
        if (shape < 68) begin
            // leave as built
        end else if (shape < 80) begin
            // stop the batch early, possibly inside a header or a payload
            if (batch_q.size() > 1) begin
                cut = $urandom_range(batch_q.size() - 1, 1);
                while (batch_q.size() > cut)
                    void'(batch_q.pop_back());
            end
        end else if (shape < 90) begin
            // header that runs past the byte limit, then some trailing bytes
            repeat ($urandom_range(8, 6)) batch_q.push_back(8'(8'h80 | $urandom_range(127)));
            repeat ($urandom_range(3)) batch_q.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(1) == 0)
                batch_q.delete();
            repeat ($urandom_range(16, 1)) batch_q.push_back(8'($urandom_range(255)));
        end
    endtask

    // Stop offering and wait until every due result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    initial begin
        int goal;
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Phase 1: sender idles rarely, receiver mostly.
        tx_idle_pct = 6;
        rx_idle_pct <= 86;

        foreach (directed[i])
            send_byte(directed[i][7:0], directed[i][8]);
        drain();

        goal = live_bytes;
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 6;
                    rx_idle_pct <= 86;
                end
                1: begin
                    tx_idle_pct = 86;
                    rx_idle_pct <= 6;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    hold_req <= 1'b1;
                end
            endcase
            goal = goal + PHASE_BYTES;
            while (live_bytes < goal) begin
                build_random_batch();
                send_batch();
            end
            // pause the sender until all results of this phase are in
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Sent %0d bytes (%0d outside dropped runs); checked %0d results, %0d of them errors.",
                 n_sent, live_bytes, results, error_results);
        $display("Input stalled for %0d cycles under receiver back-pressure.", stall_cycles);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Timeout: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/vlpd_pkg.sv
rtl/core/vlpd_decode.sv
rtl/core/vlpd_out_reg.sv
rtl/core/varint_length_prefix_deframer_top.sv
sim/vlpd_result_checker.sv
sim/tb_varint_length_prefix_deframer_top.sv
